[rtl/bps_pkg.sv]
package bps_pkg;

   localparam logic [1:0] OP_TICK   = 2'd0;
   localparam logic [1:0] OP_PAIR   = 2'd1;
   localparam logic [1:0] OP_SYMBOL = 2'd2;

   localparam logic [1:0] PH_IDLE    = 2'd0;
   localparam logic [1:0] PH_BEEPING = 2'd1;
   localparam logic [1:0] PH_WAITING = 2'd2;

   localparam logic [7:0] SYM_DOT   = 8'h2E;
   localparam logic [7:0] SYM_DASH  = 8'h5F;
   localparam logic [7:0] SYM_SPACE = 8'h20;

   localparam logic [15:0] DOT_BEEP_MS   = 16'd150;
   localparam logic [15:0] DASH_BEEP_MS  = 16'd400;
   localparam logic [15:0] SPACE_BEEP_MS = 16'd0;
   localparam logic [15:0] MARK_PAUSE_MS = 16'd50;
   localparam logic [15:0] SPACE_PAUSE_MS = 16'd150;

   localparam logic CSR_ACTIVE_LOW = 1'b0;

endpackage

[rtl/beep_pattern_sequencer.sv]
// Buzzer pattern sequencer.
// Input transactions are taken on start while busy is low; busy is always low,
// so one transaction can be issued every cycle. Operations: tick (advance the
// beep/pause machine using req_now_ms), enqueue a beep/pause pair, or enqueue a
// pattern symbol ('.', '_' or space; other bytes are ignored).
// Each transaction yields one result in the cycle after acceptance: rsp_valid is
// high for exactly that cycle with rsp_buzzer_level, rsp_rejected (enqueue into
// a full queue) and rsp_queued. The receiver cannot stall; results are not held.
// Throughput is one transaction per cycle; a single register stage follows the
// queue and phase update logic.
// The pair queue is a QUEUE_DEPTH-entry memory; the head pair and the one after
// it are kept in registers, the latter refilled from the memory read port on a pop.
// Reset empties the queue, returns to idle with the tone off and sets
// active_low. The APB register at address 0 holds active_low.
module beep_pattern_sequencer #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_operation,
   input  logic [31:0] req_now_ms,
   input  logic [15:0] req_beep_ms,
   input  logic [15:0] req_pause_ms,
   input  logic [7:0]  req_symbol,
   output logic        rsp_valid,
   output logic        rsp_buzzer_level,
   output logic        rsp_rejected,
   output logic [4:0]  rsp_queued,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import bps_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);

   logic [15:0] beep_mem  [QUEUE_DEPTH];
   logic [15:0] pause_mem [QUEUE_DEPTH];

   logic [PTR_W-1:0] read_ptr_ff, read_ptr_in, write_ptr_ff, write_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [1:0]       phase_ff, phase_in;
   logic [31:0]      phase_start_ff, phase_start_in;
   logic             tone_on_ff, tone_on_in;
   logic             active_low_ff;
   logic [15:0]      head_beep_ff, head_beep_in, head_pause_ff, head_pause_in;
   logic [15:0]      next_beep_ff, next_pause_ff;

   logic             rsp_valid_ff, rsp_level_ff, rsp_rejected_ff;
   logic [4:0]       rsp_queued_ff;

   logic             accept, push_req, push_ok, pop, full;
   logic [15:0]      push_beep, push_pause;
   logic [31:0]      elapsed;
   logic [PTR_W-1:0] read_ptr_inc, prefetch_addr;

   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
      next_slot = (p == LAST_SLOT) ? '0 : p + PTR_W'(1);
   endfunction

   assign busy   = 1'b0;
   assign pready = 1'b1;
   assign prdata = (paddr[2] == CSR_ACTIVE_LOW) ? {31'd0, active_low_ff} : 32'd0;

   assign accept        = start && !busy;
   assign full          = (count_ff == FULL_COUNT);
   assign elapsed       = req_now_ms - phase_start_ff;
   assign read_ptr_inc  = next_slot(read_ptr_ff);
   assign prefetch_addr = next_slot(read_ptr_inc);

   always_comb begin
      push_req   = 1'b0;
      push_beep  = req_beep_ms;
      push_pause = req_pause_ms;
      unique case (req_operation)
         OP_PAIR: begin
            push_req = 1'b1;
         end
         OP_SYMBOL: begin
            unique case (req_symbol)
               SYM_DOT: begin
                  push_req   = 1'b1;
                  push_beep  = DOT_BEEP_MS;
                  push_pause = MARK_PAUSE_MS;
               end
               SYM_DASH: begin
                  push_req   = 1'b1;
                  push_beep  = DASH_BEEP_MS;
                  push_pause = MARK_PAUSE_MS;
               end
               SYM_SPACE: begin
                  push_req   = 1'b1;
                  push_beep  = SPACE_BEEP_MS;
                  push_pause = SPACE_PAUSE_MS;
               end
               default: push_req = 1'b0;
            endcase
         end
         default: push_req = 1'b0;
      endcase
      push_req = push_req && accept;
      push_ok  = push_req && !full;
   end

   always_comb begin
      read_ptr_in    = read_ptr_ff;
      write_ptr_in   = write_ptr_ff;
      count_in       = count_ff;
      phase_in       = phase_ff;
      phase_start_in = phase_start_ff;
      tone_on_in     = tone_on_ff;
      head_beep_in   = head_beep_ff;
      head_pause_in  = head_pause_ff;
      pop            = 1'b0;
      if (push_ok) begin
         write_ptr_in = next_slot(write_ptr_ff);
         count_in     = count_ff + CNT_W'(1);
         if (count_ff == '0) begin
            head_beep_in  = push_beep;
            head_pause_in = push_pause;
         end
      end
      if (accept && req_operation == OP_TICK && count_ff != '0) begin
         unique case (phase_ff)
            PH_BEEPING: begin
               if (elapsed >= {16'd0, head_beep_ff}) begin
                  tone_on_in     = 1'b0;
                  phase_start_in = req_now_ms;
                  phase_in       = PH_WAITING;
               end
            end
            PH_WAITING: begin
               if (elapsed >= {16'd0, head_pause_ff}) begin
                  pop           = 1'b1;
                  read_ptr_in   = read_ptr_inc;
                  count_in      = count_ff - CNT_W'(1);
                  phase_in      = PH_IDLE;
                  head_beep_in  = next_beep_ff;
                  head_pause_in = next_pause_ff;
               end
            end
            default: begin
               if (head_beep_ff != 16'd0) begin
                  tone_on_in = 1'b1;
                  phase_in   = PH_BEEPING;
               end else begin
                  phase_in = PH_WAITING;
               end
               phase_start_in = req_now_ms;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         beep_mem[write_ptr_ff]  <= push_beep;
         pause_mem[write_ptr_ff] <= push_pause;
      end
      if (pop) begin
         next_beep_ff  <= beep_mem[prefetch_addr];
         next_pause_ff <= pause_mem[prefetch_addr];
      end else if (push_ok && count_ff == CNT_W'(1)) begin
         next_beep_ff  <= push_beep;
         next_pause_ff <= push_pause;
      end
   end

   always_ff @(posedge clock) begin
      head_beep_ff    <= head_beep_in;
      head_pause_ff   <= head_pause_in;
      rsp_level_ff    <= tone_on_in ^ active_low_ff;
      rsp_rejected_ff <= push_req && full;
      rsp_queued_ff   <= 5'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         read_ptr_ff    <= '0;
         write_ptr_ff   <= '0;
         count_ff       <= '0;
         phase_ff       <= PH_IDLE;
         phase_start_ff <= '0;
         tone_on_ff     <= 1'b0;
         active_low_ff  <= 1'b1;
         rsp_valid_ff   <= 1'b0;
      end else begin
         read_ptr_ff    <= read_ptr_in;
         write_ptr_ff   <= write_ptr_in;
         count_ff       <= count_in;
         phase_ff       <= phase_in;
         phase_start_ff <= phase_start_in;
         tone_on_ff     <= tone_on_in;
         rsp_valid_ff   <= accept;
         if (psel && penable && pwrite && pready && paddr[2] == CSR_ACTIVE_LOW) begin
            active_low_ff <= pwdata[0];
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_buzzer_level = rsp_level_ff;
   assign rsp_rejected     = rsp_rejected_ff;
   assign rsp_queued       = rsp_queued_ff;

endmodule

[bench/beep_pattern_sequencer_test.sv]
`timescale 1ns / 100ps

module beep_pattern_sequencer_test;
   import bps_pkg::*;

   localparam int DEPTH = 16;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic [2:0] ACTIVE_LOW_ADDR = 3'(4 * int'(CSR_ACTIVE_LOW));
   localparam int SCRIPT_LEN = 25;

   typedef struct packed {
      logic       level;
      logic       rejected;
      logic [4:0] queued;
   } result_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] now;
      logic [15:0] beep;
      logic [15:0] pause;
      logic [7:0]  sym;
      logic        typed;
      result_type  res;
   } row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_operation;
   logic [31:0] req_now_ms;
   logic [15:0] req_beep_ms;
   logic [15:0] req_pause_ms;
   logic [7:0]  req_symbol;
   logic        rsp_valid;
   logic        rsp_buzzer_level;
   logic        rsp_rejected;
   logic [4:0]  rsp_queued;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   // travels with each transaction: a hand-typed result overrides the prediction
   logic        typed_valid;
   result_type  typed_result;

   // predictor state
   logic [15:0] beep_mem [DEPTH];
   logic [15:0] pause_mem [DEPTH];
   logic [3:0]  head_ptr;
   logic [3:0]  tail_ptr;
   logic [4:0]  fill;
   logic [1:0]  phase;
   logic [31:0] phase_began;
   logic        tone;
   logic        polarity_low;

   result_type  pending_results [$];
   int          mismatch_count = 0;
   int          items_sent = 0;
   int          burst_left;
   logic [31:0] ms_clock;
   row_type     script [SCRIPT_LEN];

   beep_pattern_sequencer #(.QUEUE_DEPTH(DEPTH)) uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_now_ms(req_now_ms),
      .req_beep_ms(req_beep_ms), .req_pause_ms(req_pause_ms), .req_symbol(req_symbol),
      .rsp_valid(rsp_valid), .rsp_buzzer_level(rsp_buzzer_level),
      .rsp_rejected(rsp_rejected), .rsp_queued(rsp_queued),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic flag_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 40) $display("mismatch at %0t: %s", $time, what);
   endtask

   function automatic logic push_pair(input logic [15:0] beep, input logic [15:0] pause);
      if (fill >= 5'(DEPTH)) return 1'b1;
      beep_mem[tail_ptr] = beep;
      pause_mem[tail_ptr] = pause;
      tail_ptr++;
      fill++;
      return 1'b0;
   endfunction

   function automatic result_type sequencer_step(input logic [1:0] op, input logic [31:0] now,
                                                 input logic [15:0] beep,
                                                 input logic [15:0] pause,
                                                 input logic [7:0] sym);
      result_type  r;
      logic        rej;
      logic [31:0] elapsed;
      rej = 1'b0;
      case (op)
         OP_TICK: if (fill != 0) begin
            elapsed = now - phase_began;
            case (phase)
               PH_BEEPING: if (elapsed >= {16'd0, beep_mem[head_ptr]}) begin
                  tone = 1'b0;
                  phase_began = now;
                  phase = PH_WAITING;
               end
               PH_WAITING: if (elapsed >= {16'd0, pause_mem[head_ptr]}) begin
                  head_ptr++;
                  fill--;
                  phase = PH_IDLE;
               end
               default: begin
                  if (beep_mem[head_ptr] != 0) begin
                     tone = 1'b1;
                     phase = PH_BEEPING;
                  end else begin
                     phase = PH_WAITING;
                  end
                  phase_began = now;
               end
            endcase
         end
         OP_PAIR: rej = push_pair(beep, pause);
         OP_SYMBOL: case (sym)
            SYM_DOT:   rej = push_pair(DOT_BEEP_MS, MARK_PAUSE_MS);
            SYM_DASH:  rej = push_pair(DASH_BEEP_MS, MARK_PAUSE_MS);
            SYM_SPACE: rej = push_pair(SPACE_BEEP_MS, SPACE_PAUSE_MS);
            default: ;
         endcase
         default: ;
      endcase
      r.level = tone ^ polarity_low;
      r.rejected = rej;
      r.queued = fill;
      return r;
   endfunction

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         head_ptr = '0;
         tail_ptr = '0;
         fill = '0;
         phase = PH_IDLE;
         phase_began = '0;
         tone = 1'b0;
         polarity_low = 1'b1;
      end else begin
         if (rsp_valid) begin
            got = '{rsp_buzzer_level, rsp_rejected, rsp_queued};
            if (pending_results.size() == 0) begin
               flag_mismatch("result with no transaction outstanding");
            end else begin
               want = pending_results.pop_front();
               if (got.level !== want.level)
                  flag_mismatch($sformatf("buzzer_level %b, expected %b", got.level, want.level));
               if (got.rejected !== want.rejected)
                  flag_mismatch($sformatf("rejected %b, expected %b", got.rejected, want.rejected));
               if (got.queued !== want.queued)
                  flag_mismatch($sformatf("queued %0d, expected %0d", got.queued, want.queued));
            end
         end
         if (psel && penable && pwrite && pready && paddr == ACTIVE_LOW_ADDR)
            polarity_low = pwdata[0];
         if (start && !busy) begin
            want = sequencer_step(req_operation, req_now_ms, req_beep_ms, req_pause_ms,
                                  req_symbol);
            if (typed_valid) want = typed_result;
            pending_results.push_back(want);
         end
      end
   end

   task automatic send(input logic [1:0] op, input logic [31:0] now, input logic [15:0] beep,
                       input logic [15:0] pause, input logic [7:0] sym,
                       input logic typed = 1'b0, input result_type res = '0);
      start <= 1'b1;
      req_operation <= op;
      req_now_ms <= now;
      req_beep_ms <= beep;
      req_pause_ms <= pause;
      req_symbol <= sym;
      typed_valid <= typed;
      typed_result <= res;
      do @(posedge clock); while (busy);
      if (op == OP_TICK || op == OP_PAIR ||
          (op == OP_SYMBOL && (sym == SYM_DOT || sym == SYM_DASH || sym == SYM_SPACE)))
         items_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 30);
      end
   endtask

   task automatic drain;
      start <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic set_polarity(input logic value);
      drain();
      repeat (2) @(posedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= ACTIVE_LOW_ADDR;
      pwdata <= {31'd0, value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[0] !== value)
         flag_mismatch($sformatf("active_low reads %b, expected %b", prdata[0], value));
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [7:0] pick_symbol;
      case ($urandom_range(0, 7))
         0, 1, 2: return SYM_DOT;
         3, 4:    return SYM_DASH;
         5, 6:    return SYM_SPACE;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic enqueue_random;
      logic [15:0] beep;
      logic [15:0] pause;
      if ($urandom_range(0, 1)) begin
         send(OP_SYMBOL, $urandom, 16'($urandom), 16'($urandom), pick_symbol());
      end else begin
         beep = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
         pause = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
         send(OP_PAIR, $urandom, beep, pause, 8'($urandom));
      end
   endtask

   task automatic tick_forward;
      ms_clock += ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 25);
      send(OP_TICK, ms_clock, 16'($urandom), 16'($urandom), 8'($urandom));
   endtask

   task automatic run_random(input int quota);
      int goal;
      goal = items_sent + quota;
      while (items_sent < goal) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               repeat ($urandom_range(1, 4)) enqueue_random();
               repeat ($urandom_range(5, 25)) tick_forward();
            end
            4: repeat (18) enqueue_random();
            5, 6: repeat ($urandom_range(10, 40)) tick_forward();
            7: repeat ($urandom_range(4, 10))
               send(2'($urandom), $urandom, 16'($urandom), 16'($urandom), 8'($urandom));
            8: begin
               ms_clock = $urandom_range(0, 1) ? $urandom
                                               : 32'hFFFF_FFFF - $urandom_range(0, 300);
               repeat ($urandom_range(5, 20)) tick_forward();
            end
            default: drain();
         endcase
      end
   endtask

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_operation <= OP_TICK;
      req_now_ms <= '0;
      req_beep_ms <= '0;
      req_pause_ms <= '0;
      req_symbol <= '0;
      typed_valid <= 1'b0;
      typed_result <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      burst_left = $urandom_range(1, 30);

      script = '{
         '{OP_TICK,   32'd0,         16'd0,      16'd0,      8'h00,     1'b1, '{1'b1, 1'b0, 5'd0}},
         '{OP_UNUSED, 32'hFFFF_FFFF, 16'hFFFF,   16'hFFFF,   8'hFF,     1'b1, '{1'b1, 1'b0, 5'd0}},
         '{OP_SYMBOL, 32'd0,         16'd0,      16'd0,      8'h78,     1'b1, '{1'b1, 1'b0, 5'd0}},
         '{OP_SYMBOL, 32'd0,         16'd0,      16'd0,      8'hFF,     1'b1, '{1'b1, 1'b0, 5'd0}},
         '{OP_SYMBOL, 32'd0,         16'd0,      16'd0,      8'h00,     1'b1, '{1'b1, 1'b0, 5'd0}},
         '{OP_SYMBOL, 32'd0,         16'd0,      16'd0,      SYM_DOT,   1'b1, '{1'b1, 1'b0, 5'd1}},
         '{OP_SYMBOL, 32'd0,         16'd0,      16'd0,      SYM_DASH,  1'b1, '{1'b1, 1'b0, 5'd2}},
         '{OP_SYMBOL, 32'd0,         16'd0,      16'd0,      SYM_SPACE, 1'b1, '{1'b1, 1'b0, 5'd3}},
         '{OP_PAIR,   32'd0,         16'hFFFF,   16'hFFFF,   8'h00,     1'b1, '{1'b1, 1'b0, 5'd4}},
         '{OP_PAIR,   32'd0,         16'd0,      16'd0,      8'h00,     1'b1, '{1'b1, 1'b0, 5'd5}},
         '{OP_PAIR,   32'd0,         16'd1,      16'd1,      8'h00,     1'b0, '0},
         '{OP_TICK,   32'd100,       16'd0,      16'd0,      8'h00,     1'b0, '0},
         '{OP_TICK,   32'd249,       16'd0,      16'd0,      8'h00,     1'b0, '0},
         '{OP_TICK,   32'd250,       16'd0,      16'd0,      8'h00,     1'b0, '0},
         '{OP_TICK,   32'd299,       16'd0,      16'd0,      8'h00,     1'b0, '0},
         '{OP_TICK,   32'd300,       16'd0,      16'd0,      8'h00,     1'b0, '0},
         '{OP_TICK,   32'hFFFF_FF00, 16'd0,      16'd0,      8'h00,     1'b0, '0},
         '{OP_TICK,   32'h0000_008F, 16'd0,      16'd0,      8'h00,     1'b0, '0},
         '{OP_TICK,   32'h0000_0090, 16'd0,      16'd0,      8'h00,     1'b0, '0},
         '{OP_TICK,   32'h0000_00C2, 16'd0,      16'd0,      8'h00,     1'b0, '0},
         '{OP_TICK,   32'h0000_00C2, 16'd0,      16'd0,      8'h00,     1'b0, '0},
         '{OP_TICK,   32'h0000_0158, 16'd0,      16'd0,      8'h00,     1'b0, '0},
         '{OP_TICK,   32'h0000_0200, 16'd0,      16'd0,      8'h00,     1'b0, '0},
         '{OP_TICK,   32'h0001_01FF, 16'd0,      16'd0,      8'h00,     1'b0, '0},
         '{OP_PAIR,   32'd0,         16'h5555,   16'hAAAA,   8'h00,     1'b0, '0}
      };

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[i])
         send(script[i].op, script[i].now, script[i].beep, script[i].pause, script[i].sym,
              script[i].typed, script[i].res);
      ms_clock = 32'h0001_01FF;

      // active-high line, then back to active-low, then active-high again
      set_polarity(1'b0);
      run_random(150);
      set_polarity(1'b1);
      run_random(150);
      set_polarity(1'b0);
      run_random(100);

      drain();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
